### design/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// shared types and constants for the integer to decimal text converter
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

    // ascii codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // double dabble nibble correction: digits of five or more get three added
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ     = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } itoa_state_t;

    // sequencer commands to the shared shift/adjust unit
    typedef struct packed {
        logic load;
        logic shift;
    } itoa_ctrl_t;

endpackage

`default_nettype wire

### design/int32_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii
// signed integer to decimal ascii text, one character per result
// ----------------------------------------------------------------------------
// once start is taken the whole magnitude is converted before the first character appears
// (one bit of the magnitude per cycle through the shared shift/add-3 unit)
// characters then follow one per cycle, text_length of them, sign first
// a new number is taken only once the last character of the previous one has left
// the receiver cannot stall: each character is shown for exactly one cycle
// reset (rst_n low, asynchronous) returns the block to idle with nothing pending
`default_nettype none

module int32_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input transfer: start while not busy
    input  wire logic                          start,
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    output logic                               busy,
    // result transfer: one character per out_valid cycle
    output logic                               out_valid,
    output logic      [7:0]                    char_code,
    output logic                               is_last,
    output logic      [3:0]                    text_length
);
    import itoa_pkg::*;

    // decimal digits needed for a VALUE_WIDTH-bit magnitude
    localparam int NDIG   = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int IDX_W  = $clog2(NDIG);
    localparam int NDIG_W = $clog2(NDIG+1);

    itoa_ctrl_t             ctrl;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
    logic [IDX_W-1:0]       pos;
    logic [NDIG_W-1:0]      ndig;
    logic [3:0]             digit;
    logic                   sign_out;

    // magnitude taken unsigned, so the most negative value needs no special path
    assign neg = value[VALUE_WIDTH-1];
    assign mag = neg ? (~value + VALUE_WIDTH'(1)) : value;

    // shared shift/add-3 unit holds the bcd digits and the live digit count
    itoa_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NDIG        (NDIG)
    ) u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .mag   (mag),
        .pos   (pos),
        .ndig  (ndig),
        .digit (digit)
    );

    // sequencer: VALUE_WIDTH shift steps, then sign and digits, most significant first
    itoa_seq #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NDIG        (NDIG)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .neg         (neg),
        .ndig        (ndig),
        .ctrl        (ctrl),
        .pos         (pos),
        .busy        (busy),
        .out_valid   (out_valid),
        .sign_out    (sign_out),
        .is_last     (is_last),
        .text_length (text_length)
    );

    // character select: minus sign or ascii digit
    assign char_code = sign_out ? CH_MINUS : (CH_ZERO + {4'b0000, digit});

endmodule

`default_nettype wire

### design/itoa_dabble.sv
// ----------------------------------------------------------------------------
// itoa_dabble
// shared shift/add-3 unit: binary magnitude to bcd, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_dabble #(
    parameter int VALUE_WIDTH = 32,
    parameter int NDIG        = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire itoa_pkg::itoa_ctrl_t          ctrl,
    input  wire logic [VALUE_WIDTH-1:0]        mag,
    input  wire logic [$clog2(NDIG)-1:0]       pos,
    output logic      [$clog2(NDIG+1)-1:0]     ndig,
    output logic      [3:0]                    digit
);
    import itoa_pkg::*;

    localparam int IDX_W  = $clog2(NDIG);
    localparam int NDIG_W = $clog2(NDIG+1);
    localparam int BCD_W  = NDIG * 4;

    logic [VALUE_WIDTH-1:0] bin_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic [BCD_W-1:0]       bcd_adj;
    logic [BCD_W-1:0]       bcd_next;
    logic [NDIG_W-1:0]      ndig_reg;
    logic [NDIG_W-1:0]      ndig_next;
    logic [IDX_W-1:0]       top_idx;
    logic [3:0]             top_nib;

    // add-3 correction on every nibble, all in parallel
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= BCD_ADJ_MIN)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + BCD_ADJ;
            else
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    assign bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_WIDTH-1]};

    // digit count grows by at most one per doubling, so only the next nibble up
    // needs a look
    assign top_idx = ndig_reg[IDX_W-1:0];
    assign top_nib = bcd_next[{top_idx, 2'b00} +: 4];

    always_comb
    begin
        ndig_next = ndig_reg;
        if ((ndig_reg != NDIG_W'(NDIG)) && (top_nib != 4'd0))
            ndig_next = ndig_reg + NDIG_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ndig_reg <= NDIG_W'(1);
        end
        else if (ctrl.load)
        begin
            ndig_reg <= NDIG_W'(1);
        end
        else if (ctrl.shift)
        begin
            ndig_reg <= ndig_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            bin_reg <= mag;
            bcd_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            bin_reg <= {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            bcd_reg <= bcd_next;
        end
    end

    assign ndig  = ndig_reg;
    assign digit = bcd_reg[{pos, 2'b00} +: 4];

endmodule

`default_nettype wire

### design/itoa_seq.sv
// ----------------------------------------------------------------------------
// itoa_seq
// sequencer: runs the conversion then steps out sign and digits
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_seq #(
    parameter int VALUE_WIDTH = 32,
    parameter int NDIG        = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          neg,
    input  wire logic [$clog2(NDIG+1)-1:0]     ndig,
    output itoa_pkg::itoa_ctrl_t               ctrl,
    output logic      [$clog2(NDIG)-1:0]       pos,
    output logic                               busy,
    output logic                               out_valid,
    output logic                               sign_out,
    output logic                               is_last,
    output logic      [3:0]                    text_length
);
    import itoa_pkg::*;

    localparam int CNT_W   = $clog2(VALUE_WIDTH+1);
    localparam int IDX_W   = $clog2(NDIG);
    localparam int NDIG_W  = $clog2(NDIG+1);
    localparam int LEN_RAW = $clog2(NDIG+2);
    localparam int LEN_W   = (LEN_RAW < 4) ? 4 : LEN_RAW;

    itoa_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic               sign_pend_reg, sign_pend_next;
    logic [IDX_W-1:0]   emit_reg, emit_next;
    logic [NDIG_W-1:0]  ndig_m1;
    logic               last_digit;
    logic [LEN_W-1:0]   len;

    assign ndig_m1    = ndig - NDIG_W'(1);
    assign last_digit = (emit_reg == ndig_m1[IDX_W-1:0]);
    assign pos        = ndig_m1[IDX_W-1:0] - emit_reg;
    assign len        = LEN_W'(ndig) + LEN_W'(neg_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            neg_reg       <= 1'b0;
            sign_pend_reg <= 1'b0;
            emit_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            neg_reg       <= neg_next;
            sign_pend_reg <= sign_pend_next;
            emit_reg      <= emit_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        sign_pend_next = sign_pend_reg;
        emit_next      = emit_reg;
        ctrl           = '0;
        busy           = 1'b1;
        out_valid      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    cnt_next   = CNT_W'(VALUE_WIDTH);
                    neg_next   = neg;
                    emit_next  = '0;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                ctrl.shift = 1'b1;
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    sign_pend_next = neg_reg;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (sign_pend_reg)
                    sign_pend_next = 1'b0;
                else if (last_digit)
                    state_next = ST_IDLE;
                else
                    emit_next = emit_reg + IDX_W'(1);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign sign_out    = sign_pend_reg;
    assign is_last     = !sign_pend_reg && last_digit;
    assign text_length = len[3:0];

endmodule

`default_nettype wire

### design/itoa_chk.sv
// ----------------------------------------------------------------------------
// itoa_chk
// port level checks for the integer to decimal text converter
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_chk (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire logic       out_valid,
    input  wire logic       is_last,
    input  wire logic [3:0] text_length
);

    // a taken transfer makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("not busy after input transfer");

    // conversion runs before any character leaves
    a_no_early_char: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !out_valid)
        else $error("character right after input transfer");

    // characters only while an item is in work
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("character while idle");

    // characters of one number come back to back with a steady length
    a_run_on: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_last |=> out_valid && (text_length == $past(text_length)))
        else $error("broken character run");

    // the last character ends the run
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_last |=> !out_valid)
        else $error("character after last");

endmodule

bind int32_to_decimal_ascii itoa_chk u_itoa_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .out_valid   (out_valid),
    .is_last     (is_last),
    .text_length (text_length)
);

`default_nettype wire

### tb/int32_to_decimal_ascii_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii_checker
// watches both transfers of the converter, predicts the decimal text of every
// accepted number and compares each character strobe in order
// ----------------------------------------------------------------------------

module int32_to_decimal_ascii_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic                   out_valid,
    input  logic [7:0]             char_code,
    input  logic                   is_last,
    input  logic [3:0]             text_length,
    output int                     error_count,
    output int                     chars_pending,
    output int                     chars_checked
);
    import itoa_pkg::*;

    localparam int MAX_CHARS = 24;
    localparam int RADIX     = 10;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic [3:0] length;
    } text_char_t;

    text_char_t expected_chars[$];
    int         mismatches = 0;
    int         compared   = 0;

    // decimal text of one number, sign first, most significant digit next
    function automatic void predict_decimal_text(input logic [VALUE_WIDTH-1:0] raw);
        logic [VALUE_WIDTH-1:0] magnitude;
        logic [7:0]             digits [MAX_CHARS];
        int                     ndigits;
        int                     total;
        logic                   negative;
        negative  = raw[VALUE_WIDTH-1];
        // two's complement negation stays exact for the most negative value
        magnitude = negative ? (~raw + 1'b1) : raw;
        ndigits   = 0;
        if (magnitude == '0) begin
            digits[0] = CH_ZERO;
            ndigits   = 1;
        end else begin
            while (magnitude != '0) begin
                digits[ndigits] = CH_ZERO + 8'(magnitude % RADIX);
                magnitude       = magnitude / RADIX;
                ndigits++;
            end
        end
        total = ndigits + (negative ? 1 : 0);
        if (negative)
            expected_chars.push_back('{CH_MINUS, 1'b0, 4'(total)});
        for (int i = ndigits - 1; i >= 0; i--)
            expected_chars.push_back('{digits[i], i == 0, 4'(total)});
    endfunction

    always @(posedge clk) begin
        text_char_t want;
        if (rst_n) begin
            if (out_valid) begin
                if (expected_chars.size() == 0) begin
                    $error("char_code %h arrived with no character pending", char_code);
                    mismatches++;
                end else begin
                    want = expected_chars.pop_front();
                    compared++;
                    if (char_code !== want.code) begin
                        $error("char_code: expected %h, actual %h", want.code, char_code);
                        mismatches++;
                    end
                    if (is_last !== want.last) begin
                        $error("is_last: expected %b, actual %b", want.last, is_last);
                        mismatches++;
                    end
                    if (text_length !== want.length) begin
                        $error("text_length: expected %0d, actual %0d",
                               want.length, text_length);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                predict_decimal_text(value);
        end
        error_count   <= mismatches;
        chars_pending <= expected_chars.size();
        chars_checked <= compared;
    end

endmodule

### tb/tb_int32_to_decimal_ascii.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_int32_to_decimal_ascii
// drives edge cases, then random bursts of signed numbers into the converter
// and lets the checker compare every emitted character against its own prediction
// ----------------------------------------------------------------------------

module tb_int32_to_decimal_ascii;

    localparam int VALUE_WIDTH  = 32;
    localparam int RANDOM_ITEMS = 346;
    localparam int CYCLE_LIMIT  = 250_000;
    // idle time after the final drain, more than one item's whole run, so this covers any tail
    localparam int TAIL_CYCLES  = 64;

    logic                          clk   = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic signed [VALUE_WIDTH-1:0] value = '0;
    logic                          busy;
    logic                          out_valid;
    logic [7:0]                    char_code;
    logic                          is_last;
    logic [3:0]                    text_length;

    int error_count;
    int chars_pending;
    int chars_checked;
    int cycle_count    = 0;
    int numbers_sent   = 0;
    int negatives_sent = 0;

    // edge cases first: zero, single digits, several power of ten boundaries,
    // and both ends of the signed range
    int directed_values [24] = '{
        0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
        12345, -67890, 999999999, 1000000000, -999999999, -1000000000,
        32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'h7fff_fffe,
        2000000000, -2000000000, 1000000001, 7
    };

    int32_to_decimal_ascii #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .value       (value),
        .busy        (busy),
        .out_valid   (out_valid),
        .char_code   (char_code),
        .is_last     (is_last),
        .text_length (text_length)
    );

    int32_to_decimal_ascii_checker #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .value         (value),
        .out_valid     (out_valid),
        .char_code     (char_code),
        .is_last       (is_last),
        .text_length   (text_length),
        .error_count   (error_count),
        .chars_pending (chars_pending),
        .chars_checked (chars_checked)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // watchdog: a hung block never drains its characters
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d characters still pending",
                 cycle_count, chars_pending);
        $display("[int32_to_decimal_ascii] ERROR");
        $finish;
    end

    // present one number and hold it until the transfer happens
    // (returns on the edge that takes it, start still high)
    task automatic send_number(input logic [VALUE_WIDTH-1:0] number);
        start <= 1'b1;
        value <= number;
        do @(posedge clk); while (busy);
        numbers_sent++;
        if (number[VALUE_WIDTH-1])
            negatives_sent++;
    endtask

    // drop start and sit until every predicted character has come out
    task automatic wait_for_drain();
        start <= 1'b0;
        do @(posedge clk); while (chars_pending != 0);
    endtask

    // random number with a spread of text lengths rather than mostly ten digits
    function automatic logic [VALUE_WIDTH-1:0] pick_number();
        int          mode;
        int          ndigits;
        longint      lo;
        longint      hi;
        longint      magnitude;
        logic [31:0] number;
        mode = $urandom_range(0, 9);
        if (mode <= 3) begin
            // raw bits, covers every bit in both states
            number = $urandom();
        end else if (mode <= 7) begin
            // uniform over a chosen digit count
            ndigits = $urandom_range(1, 10);
            lo = 1;
            repeat (ndigits - 1) lo = lo * 10;
            hi = (ndigits == 10) ? 64'd2147483647 : lo * 10 - 1;
            if (ndigits == 1)
                lo = 0;
            magnitude = $urandom_range(32'(hi), 32'(lo));
            number = $urandom_range(0, 1) ? -32'(magnitude) : 32'(magnitude);
        end else if (mode == 8) begin
            // just around a power of ten, where the digit count changes
            magnitude = 1;
            repeat ($urandom_range(1, 9)) magnitude = magnitude * 10;
            magnitude = magnitude + $urandom_range(0, 2) - 1;
            number = $urandom_range(0, 1) ? -32'(magnitude) : 32'(magnitude);
        end else begin
            // close to the ends of the signed range
            number = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                          : 32'h7fff_ffff - $urandom_range(0, 3);
        end
        return number;
    endfunction

    initial begin
        int burst;
        int gap;
        int random_sent;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed numbers back to back, start held high between them
        foreach (directed_values[i])
            send_number(directed_values[i]);

        // let everything land before the random phase
        wait_for_drain();

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && random_sent < RANDOM_ITEMS; k++) begin
                send_number(pick_number());
                random_sent++;
            end
            // gaps up past one item's length so they hit every phase of the work
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (random_sent == RANDOM_ITEMS / 2) begin
                wait_for_drain();
            end else if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("converted %0d numbers (%0d negative), %0d characters compared",
                 numbers_sent, negatives_sent, chars_checked);
        $display("mismatches %0d, characters left unmatched %0d",
                 error_count, chars_pending);
        if (error_count == 0 && chars_pending == 0) begin
            $display("[int32_to_decimal_ascii] OK");
        end else begin
            $display("[int32_to_decimal_ascii] ERROR");
        end
        $finish;
    end

endmodule

### files.f
design/itoa_pkg.sv
design/itoa_dabble.sv
design/itoa_seq.sv
design/int32_to_decimal_ascii.sv
design/itoa_chk.sv
tb/int32_to_decimal_ascii_checker.sv
tb/tb_int32_to_decimal_ascii.sv
